>>> hdl/brl_pkg.sv
package brl_pkg;

    // default coordinate width, overridable on the top level
    localparam int COORD_BITS_DEF = 11;

    // entries in the command queue between front and back, power of two
    localparam int QUEUE_DEPTH = 2;

    // operation codes of the op field
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // width of one packed command: step flag, start x/y, major limit,
    // error term, both increments and three flags
    function automatic int cmd_width(input int coord_bits);
        return 6 * coord_bits + 12;
    endfunction

endpackage

>>> hdl/brl_if.sv
interface brl_in_if #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;

    modport source (output valid, op, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, op, x_start, y_start, x_end, y_end, output ready);
endinterface

interface brl_out_if #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  pixel_valid;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;

    modport source (output valid, pixel_valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink   (input valid, pixel_valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

>>> hdl/brl_front.sv
module brl_front #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
    brl_in_if.sink                                   i_line,
    input  logic                                     i_q_ready,
    output logic                                     o_q_valid,
    output logic [brl_pkg::cmd_width(COORD_BITS)-1:0] o_q_data
);
    import brl_pkg::*;

    localparam int C = COORD_BITS;
    localparam int E = COORD_BITS + 3;

    typedef struct packed {
        logic                step;
        logic [C-1:0]        start_x;
        logic [C-1:0]        start_y;
        logic [C-1:0]        major_limit;
        logic signed [E-1:0] err_init;
        logic [C+1:0]        inc_straight;
        logic signed [E-1:0] inc_diag;
        logic                x_is_major;
        logic                minor_down;
        logic                busy;
    } t_cmd;

    logic [C-1:0] dx;
    logic [C-1:0] dy;
    logic [C-1:0] dmaj;
    logic [C-1:0] dmin;
    logic         x_major;
    logic         swap;
    logic [C-1:0] sx;
    logic [C-1:0] sy;
    logic [C-1:0] fx;
    logic [C-1:0] fy;
    logic [E-1:0] dmaj_ext;
    logic [E-1:0] dmin2_ext;
    t_cmd         cmd;

    always_comb begin
        dx      = (i_line.x_end > i_line.x_start) ? i_line.x_end - i_line.x_start
                                                  : i_line.x_start - i_line.x_end;
        dy      = (i_line.y_end > i_line.y_start) ? i_line.y_end - i_line.y_start
                                                  : i_line.y_start - i_line.y_end;
        x_major = (dx >= dy);
        dmaj    = x_major ? dx : dy;
        dmin    = x_major ? dy : dx;

        // order endpoints so the major coordinate rises; ties take the second one
        if (x_major) begin
            swap = !(i_line.x_start < i_line.x_end);
        end else begin
            swap = !(i_line.y_start < i_line.y_end);
        end
        sx = swap ? i_line.x_end   : i_line.x_start;
        sy = swap ? i_line.y_end   : i_line.y_start;
        fx = swap ? i_line.x_start : i_line.x_end;
        fy = swap ? i_line.y_start : i_line.y_end;

        dmaj_ext  = {3'b000, dmaj};
        dmin2_ext = {2'b00, dmin, 1'b0};

        cmd.step         = (i_line.op == OP_STEP);
        cmd.start_x      = sx;
        cmd.start_y      = sy;
        cmd.major_limit  = x_major ? fx : fy;
        cmd.err_init     = signed'(dmin2_ext - dmaj_ext);
        cmd.inc_straight = {1'b0, dmin, 1'b0};
        cmd.inc_diag     = signed'(dmin2_ext - {dmaj_ext[E-2:0], 1'b0});
        cmd.x_is_major   = x_major;
        cmd.minor_down   = x_major ? (fy < sy) : (fx < sx);
        cmd.busy         = (dmaj != '0);
    end

    assign i_line.ready = i_q_ready;
    assign o_q_valid    = i_line.valid;
    assign o_q_data     = cmd;

endmodule

>>> hdl/brl_queue.sv
module brl_queue #(
    parameter int DATA_BITS = brl_pkg::cmd_width(brl_pkg::COORD_BITS_DEF)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_valid,
    output logic                 o_push_ready,
    input  logic [DATA_BITS-1:0] i_push_data,
    output logic                 o_pop_valid,
    input  logic                 i_pop_ready,
    output logic [DATA_BITS-1:0] o_pop_data
);
    import brl_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [DATA_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [AW-1:0]        r_wr_ptr;
    logic [AW-1:0]        r_rd_ptr;
    logic [AW:0]          r_count;
    logic                 push;
    logic                 pop;

    assign o_push_ready = (r_count != (AW+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/brl_back.sv
module brl_back #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cmd_valid,
    output logic                                     o_cmd_ready,
    input  logic [brl_pkg::cmd_width(COORD_BITS)-1:0] i_cmd,
    brl_out_if.source                                o_pixel
);
    import brl_pkg::*;

    localparam int C = COORD_BITS;
    localparam int E = COORD_BITS + 3;
    localparam logic [C-1:0] ONE = C'(1);

    typedef struct packed {
        logic                step;
        logic [C-1:0]        start_x;
        logic [C-1:0]        start_y;
        logic [C-1:0]        major_limit;
        logic signed [E-1:0] err_init;
        logic [C+1:0]        inc_straight;
        logic signed [E-1:0] inc_diag;
        logic                x_is_major;
        logic                minor_down;
        logic                busy;
    } t_cmd;

    // line state
    logic                r_busy,  n_busy;
    logic [C-1:0]        r_cur_x, n_cur_x;
    logic [C-1:0]        r_cur_y, n_cur_y;
    logic [C-1:0]        r_limit, n_limit;
    logic signed [E-1:0] r_err,   n_err;
    logic [C+1:0]        r_inc_s, n_inc_s;
    logic signed [E-1:0] r_inc_d, n_inc_d;
    logic                r_xmaj,  n_xmaj;
    logic                r_mdown, n_mdown;

    // output register
    logic                r_out_valid, n_out_valid;
    logic                r_pix_valid, n_pix_valid;
    logic [C-1:0]        r_pix_x,     n_pix_x;
    logic [C-1:0]        r_pix_y,     n_pix_y;
    logic                r_pix_last,  n_pix_last;

    t_cmd                cmd;
    logic                pop;
    logic                diag;
    logic signed [E-1:0] err_step;
    logic [C-1:0]        step_x;
    logic [C-1:0]        step_y;
    logic [C-1:0]        step_major;
    logic                step_last;

    assign o_cmd_ready = !r_out_valid || o_pixel.ready;

    always_comb begin
        cmd  = t_cmd'(i_cmd);
        pop  = i_cmd_valid && o_cmd_ready;

        // one step of the error walk
        diag     = !r_err[E-1];
        err_step = r_err + (diag ? r_inc_d : signed'({1'b0, r_inc_s}));
        if (r_xmaj) begin
            step_x = r_cur_x + ONE;
            step_y = diag ? (r_mdown ? r_cur_y - ONE : r_cur_y + ONE) : r_cur_y;
            step_major = step_x;
        end else begin
            step_y = r_cur_y + ONE;
            step_x = diag ? (r_mdown ? r_cur_x - ONE : r_cur_x + ONE) : r_cur_x;
            step_major = step_y;
        end
        step_last = (step_major == r_limit);

        n_busy  = r_busy;
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_limit = r_limit;
        n_err   = r_err;
        n_inc_s = r_inc_s;
        n_inc_d = r_inc_d;
        n_xmaj  = r_xmaj;
        n_mdown = r_mdown;

        n_out_valid = r_out_valid && !o_pixel.ready;
        n_pix_valid = r_pix_valid;
        n_pix_x     = r_pix_x;
        n_pix_y     = r_pix_y;
        n_pix_last  = r_pix_last;

        if (pop) begin
            n_out_valid = 1'b1;
            case (cmd.step)
                OP_START: begin
                    n_busy      = cmd.busy;
                    n_cur_x     = cmd.start_x;
                    n_cur_y     = cmd.start_y;
                    n_limit     = cmd.major_limit;
                    n_err       = cmd.err_init;
                    n_inc_s     = cmd.inc_straight;
                    n_inc_d     = cmd.inc_diag;
                    n_xmaj      = cmd.x_is_major;
                    n_mdown     = cmd.minor_down;
                    n_pix_valid = 1'b1;
                    n_pix_x     = cmd.start_x;
                    n_pix_y     = cmd.start_y;
                    n_pix_last  = !cmd.busy;
                end
                OP_STEP: begin
                    if (r_busy) begin
                        n_err       = err_step;
                        n_cur_x     = step_x;
                        n_cur_y     = step_y;
                        n_busy      = !step_last;
                        n_pix_valid = 1'b1;
                        n_pix_x     = step_x;
                        n_pix_y     = step_y;
                        n_pix_last  = step_last;
                    end else begin
                        // step with no line in progress
                        n_pix_valid = 1'b0;
                        n_pix_x     = '0;
                        n_pix_y     = '0;
                        n_pix_last  = 1'b0;
                    end
                end
                default: begin
                    n_pix_valid = 1'b0;
                    n_pix_x     = '0;
                    n_pix_y     = '0;
                    n_pix_last  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_limit     <= '0;
            r_err       <= '0;
            r_inc_s     <= '0;
            r_inc_d     <= '0;
            r_xmaj      <= 1'b0;
            r_mdown     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_limit     <= n_limit;
            r_err       <= n_err;
            r_inc_s     <= n_inc_s;
            r_inc_d     <= n_inc_d;
            r_xmaj      <= n_xmaj;
            r_mdown     <= n_mdown;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix_valid <= n_pix_valid;
        r_pix_x     <= n_pix_x;
        r_pix_y     <= n_pix_y;
        r_pix_last  <= n_pix_last;
    end

    assign o_pixel.valid       = r_out_valid;
    assign o_pixel.pixel_valid = r_pix_valid;
    assign o_pixel.pixel_x     = r_pix_x;
    assign o_pixel.pixel_y     = r_pix_y;
    assign o_pixel.last_pixel  = r_pix_last;

endmodule

>>> hdl/bresenham_line_rasterizer.sv
// a transaction, start or step, goes into the command queue, is popped by the
// back end, and its pixel leaves the output register; the error-term update is
// combinational: one transaction and one pixel per cycle while the sink is ready
// reset: synchronous active-low i_rst_n empties the command queue and the output
// register and leaves the block idle with all line state at zero
module bresenham_line_rasterizer #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    brl_in_if.sink    i_line,
    brl_out_if.source o_pixel
);
    import brl_pkg::*;

    localparam int CMD_W = cmd_width(COORD_BITS);

    logic             front_valid;
    logic             front_ready;
    logic [CMD_W-1:0] front_data;
    logic             back_valid;
    logic             back_ready;
    logic [CMD_W-1:0] back_data;

    brl_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_line    (i_line),
        .i_q_ready (front_ready),
        .o_q_valid (front_valid),
        .o_q_data  (front_data)
    );

    brl_queue #(
        .DATA_BITS (CMD_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_data),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_data   (back_data)
    );

    brl_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (back_valid),
        .o_cmd_ready (back_ready),
        .i_cmd       (back_data),
        .o_pixel     (o_pixel)
    );

endmodule

>>> bench/bresenham_line_rasterizer_test.sv
`timescale 1ns / 100ps

module bresenham_line_rasterizer_test;

    import brl_pkg::*;

    localparam int CB          = COORD_BITS_DEF;
    localparam int COORD_MAX   = (1 << CB) - 1;
    localparam int ITEM_TARGET = 1350;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 40;

    typedef logic [CB-1:0] t_coord;

    typedef struct packed {
        logic   op;
        t_coord xs;
        t_coord ys;
        t_coord xe;
        t_coord ye;
    } t_line_cmd;

    typedef struct packed {
        logic   pix_valid;
        t_coord px;
        t_coord py;
        logic   last;
    } t_pixel;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    brl_in_if  #(.COORD_BITS(CB)) line_if ();
    brl_out_if #(.COORD_BITS(CB)) pixel_if ();

    bresenham_line_rasterizer #(.COORD_BITS(CB)) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_line  (line_if),
        .o_pixel (pixel_if)
    );

    t_line_cmd cmd_queue[$];
    t_pixel    pixel_queue[$];

    // predictor state of the rasterizer
    logic                 line_busy;
    t_coord               pos_x, pos_y, far_major;
    logic signed [CB+2:0] err_acc;
    logic        [CB+1:0] step_straight;
    logic signed [CB+2:0] step_diag;
    logic                 x_major, minor_dec;

    int item_total = 0;
    int errors = 0;
    int starts_sent = 0;
    int pixels_checked = 0;
    int idle_steps_seen = 0;
    int lines_finished = 0;
    int quiet_cycles = 0;
    int send_calm = 0;
    int recv_calm = 0;
    int send_wait = 0;
    int recv_wait = 0;
    t_line_cmd cur_cmd;
    t_pixel    want;
    t_pixel    got;

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) calm = $urandom_range(10, 40);
        return $urandom_range(0, 6);
    endfunction

    task automatic predict_pixel(input t_line_cmd cmd, output t_pixel res);
        t_coord sx, sy, fx, fy, major;
        int     adx, ady, dmaj, dmin;
        logic   diag;
        res = '0;
        if (cmd.op == OP_START) begin
            adx = (cmd.xe > cmd.xs) ? cmd.xe - cmd.xs : cmd.xs - cmd.xe;
            ady = (cmd.ye > cmd.ys) ? cmd.ye - cmd.ys : cmd.ys - cmd.ye;
            x_major = adx >= ady;
            // order endpoints so the major coordinate rises; ties take the second one
            if (x_major) begin
                dmaj = adx;
                dmin = ady;
                if (cmd.xs < cmd.xe) begin
                    sx = cmd.xs; sy = cmd.ys; fx = cmd.xe; fy = cmd.ye;
                end else begin
                    sx = cmd.xe; sy = cmd.ye; fx = cmd.xs; fy = cmd.ys;
                end
                far_major = fx;
                minor_dec = fy < sy;
            end else begin
                dmaj = ady;
                dmin = adx;
                if (cmd.ys < cmd.ye) begin
                    sx = cmd.xs; sy = cmd.ys; fx = cmd.xe; fy = cmd.ye;
                end else begin
                    sx = cmd.xe; sy = cmd.ye; fx = cmd.xs; fy = cmd.ys;
                end
                far_major = fy;
                minor_dec = fx < sx;
            end
            err_acc       = (CB+3)'(2 * dmin - dmaj);
            step_straight = (CB+2)'(2 * dmin);
            step_diag     = (CB+3)'(2 * (dmin - dmaj));
            pos_x         = sx;
            pos_y         = sy;
            line_busy     = dmaj != 0;
            res = '{pix_valid: 1'b1, px: sx, py: sy, last: !line_busy};
        end else if (line_busy) begin
            diag = !err_acc[CB+2];
            err_acc = err_acc + (diag ? step_diag : $signed({1'b0, step_straight}));
            if (x_major) begin
                pos_x = pos_x + 1'b1;
                if (diag) pos_y = minor_dec ? pos_y - 1'b1 : pos_y + 1'b1;
                major = pos_x;
            end else begin
                pos_y = pos_y + 1'b1;
                if (diag) pos_x = minor_dec ? pos_x - 1'b1 : pos_x + 1'b1;
                major = pos_y;
            end
            if (major == far_major) line_busy = 1'b0;
            res = '{pix_valid: 1'b1, px: pos_x, py: pos_y, last: !line_busy};
        end
    endtask

    task automatic add_start(input int xs, input int ys, input int xe, input int ye);
        cmd_queue.push_back('{OP_START, t_coord'(xs), t_coord'(ys), t_coord'(xe), t_coord'(ye)});
        item_total++;
    endtask

    // step transactions carry random coordinates, which the block must ignore
    task automatic add_steps(input int n);
        repeat (n) begin
            cmd_queue.push_back('{OP_STEP, t_coord'($urandom), t_coord'($urandom),
                                  t_coord'($urandom), t_coord'($urandom)});
            item_total++;
        end
    endtask

    function automatic int near_coord(input int v);
        int t;
        t = v + int'($urandom_range(0, 48)) - 24;
        if (t < 0) t = 0;
        if (t > COORD_MAX) t = COORD_MAX;
        return t;
    endfunction

    initial begin
        line_if.valid   = 1'b0;
        line_if.op      = OP_STEP;
        line_if.x_start = '0;
        line_if.y_start = '0;
        line_if.x_end   = '0;
        line_if.y_end   = '0;
        pixel_if.ready  = 1'b0;
    end

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            line_if.valid <= 1'b0;
            send_wait     <= 0;
            line_busy     = 1'b0;
            pos_x         = '0;
            pos_y         = '0;
            far_major     = '0;
            err_acc       = '0;
            step_straight = '0;
            step_diag     = '0;
            x_major       = 1'b0;
            minor_dec     = 1'b0;
        end else if (!line_if.valid || line_if.ready) begin
            if (line_if.valid) begin
                predict_pixel(cur_cmd, want);
                pixel_queue.push_back(want);
                if (cur_cmd.op == OP_START) starts_sent++;
            end
            if (send_wait != 0 || cmd_queue.size() == 0) begin
                line_if.valid <= 1'b0;
                if (send_wait != 0) send_wait <= send_wait - 1;
            end else begin
                cur_cmd = cmd_queue.pop_front();
                line_if.op      <= cur_cmd.op;
                line_if.x_start <= cur_cmd.xs;
                line_if.y_start <= cur_cmd.ys;
                line_if.x_end   <= cur_cmd.xe;
                line_if.y_end   <= cur_cmd.ye;
                line_if.valid   <= 1'b1;
                send_wait       <= draw_wait(send_calm);
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            pixel_if.ready <= 1'b0;
            recv_wait      = 0;
        end else begin
            if (pixel_if.valid && pixel_if.ready) begin
                got = '{pixel_if.pixel_valid, pixel_if.pixel_x, pixel_if.pixel_y,
                        pixel_if.last_pixel};
                if (pixel_queue.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected pixel valid=%0b x=%0d y=%0d last=%0b",
                                 $time, got.pix_valid, got.px, got.py, got.last);
                end else begin
                    want = pixel_queue.pop_front();
                    pixels_checked++;
                    if (!want.pix_valid) idle_steps_seen++;
                    if (want.pix_valid && want.last) lines_finished++;
                    if (got !== want) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: pixel mismatch: expected valid=%0b x=%0d y=%0d",
                                     $time, want.pix_valid, want.px, want.py,
                                     " last=%0b, got valid=%0b x=%0d y=%0d last=%0b",
                                     want.last, got.pix_valid, got.px, got.py, got.last);
                    end
                end
                recv_wait = draw_wait(recv_calm);
            end
            if (recv_wait != 0) begin
                pixel_if.ready <= 1'b0;
                recv_wait--;
            end else begin
                pixel_if.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((line_if.valid && line_if.ready) || (pixel_if.valid && pixel_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int xa, ya, xb, yb, dmaj, kind;

        // step while idle, then a single-pixel line
        add_steps(1);
        add_start(5, 5, 5, 5);
        add_steps(1);
        // 45 degree tie, x major, minor falling, cut short by a new start
        add_start(0, COORD_MAX, COORD_MAX, 0);
        add_steps(2);
        // endpoints given right to left
        add_start(COORD_MAX, 0, COORD_MAX - 3, 2);
        add_steps(4);
        // y major, minor rising and falling
        add_start(2, 7, 0, 4);
        add_steps(3);
        add_start(1, 0, 0, 2);
        add_steps(2);
        // shallow rising line and a horizontal one at the edge
        add_start(0, 0, 2, 1);
        add_steps(2);
        add_start(COORD_MAX, 5, COORD_MAX - 2, 5);
        add_steps(3);

        while (item_total < ITEM_TARGET) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                cmd_queue.push_back(t_line_cmd'({$urandom, $urandom}));
                item_total++;
            end else if (kind < 3) begin
                // long line anywhere, abandoned early
                add_start($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                          $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
                add_steps($urandom_range(0, 30));
            end else begin
                xa = $urandom_range(0, COORD_MAX);
                ya = $urandom_range(0, COORD_MAX);
                xb = near_coord(xa);
                yb = near_coord(ya);
                if ($urandom_range(0, 9) == 0) yb = ya;
                if ($urandom_range(0, 9) == 0) xb = xa;
                dmaj = (xb > xa) ? xb - xa : xa - xb;
                if (((yb > ya) ? yb - ya : ya - yb) > dmaj)
                    dmaj = (yb > ya) ? yb - ya : ya - yb;
                add_start(xa, ya, xb, yb);
                if ($urandom_range(0, 7) == 0)
                    add_steps($urandom_range(0, dmaj));
                else
                    add_steps(dmaj + $urandom_range(0, 2));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || line_if.valid || pixel_queue.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("sent %0d transactions (%0d line starts) with random source and sink gaps",
                 item_total, starts_sent);
        $display("checked %0d pixels: %0d lines run to their end, %0d idle steps",
                 pixels_checked, lines_finished, idle_steps_seen);
        if (errors == 0 && pixel_queue.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/brl_pkg.sv
hdl/brl_if.sv
hdl/brl_front.sv
hdl/brl_queue.sv
hdl/brl_back.sv
hdl/bresenham_line_rasterizer.sv
bench/bresenham_line_rasterizer_test.sv
